// ----- sv/scla_pkg.sv -----
`default_nettype none
package scla_pkg;

    // input beat kinds (s_tuser)
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_OVF  = 1'b1;

    // output beat kinds (m_tuser)
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    localparam int LEN_W   = 4;
    localparam int TDATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORK,
        ST_ECHO,
        ST_CR,
        ST_LF,
        ST_CMD
    } state_t;

endpackage
`default_nettype wire

// ----- sv/scla_line_ram.sv -----
`default_nettype none
module scla_line_ram #(
    parameter int DEPTH = 15,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- sv/serial_command_line_assembler.sv -----
`default_nettype none
// Serial command line assembler with terminal echo.
//
// Slave channel: one beat per received event. s_tuser = cmd (0 = received
// byte in s_tdata, 1 = receive overflow, which clears the line silently).
// Master channel: echo beats (m_tuser = 0) and command beats (m_tuser = 1);
// m_tlast marks the final beat caused by one input beat.
//
// One input beat is worked on at a time. An accepted beat is registered,
// decoded in ST_WORK, and its first output beat is loaded from ST_ECHO or
// ST_CR, terminators included. A terminator emits CR and LF, then the
// command bytes stream out one per cycle while m_tready does not stall, read
// from the line RAM, whose read is prefetched one address ahead. The line
// RAM has a single read port and the output register holds one beat.
//
// Reset clears the fill count, the overflow flag, the output valid flag and
// the sequencer; the line RAM holds no reset and needs no clearing pass,
// since only entries below the fill count are read.
// A stall on m_tready simply holds the output register and the sequencer;
// nothing is dropped. A new input may be taken as soon as the last output
// beat of the previous one is loaded, while that beat still waits.
module serial_command_line_assembler #(
    parameter int LINE_CAPACITY = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  wire logic                         s_tuser,   // [0] cmd
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [scla_pkg::TDATA_W-1:0]      m_tdata,   // [7:0] out_byte,
                                                         // [11:8] command_length
    output logic                              m_tuser,   // [0] kind
    output logic                              m_tlast    // last_of_run
);

    import scla_pkg::*;

    localparam int STORE_DEPTH = LINE_CAPACITY - 1;
    localparam int CW = $clog2(LINE_CAPACITY);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    state_t state_reg, state_next;

    // accepted item
    logic       cmd_reg, cmd_next;
    logic [7:0] byte_reg, byte_next;

    // line state
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] idx_reg, idx_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic             kind_reg, kind_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic [LEN_W-1:0] olen_reg, olen_next;
    logic             olast_reg, olast_next;

    logic          out_free;
    logic          out_load;
    logic          printable;
    logic          is_term;
    logic          has_cmd;
    logic          cmd_last;
    logic          wr_en;
    logic [CW-1:0] rd_idx;
    logic [7:0]    rd_data;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign printable = byte_reg inside {[PRINT_LO:PRINT_HI]};
    assign is_term   = (byte_reg == CH_CR) || (byte_reg == CH_LF);
    assign has_cmd   = (count_reg != '0) && !ovf_reg;
    assign cmd_last  = (idx_reg == count_reg - CW'(1));

    // prefetch the next stored byte as soon as the current one is taken
    assign rd_idx = (state_reg == ST_CMD && out_free && !cmd_last) ?
                    idx_reg + CW'(1) : idx_reg;

    scla_line_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (byte_reg),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        byte_reg  <= byte_next;
        kind_reg  <= kind_next;
        obyte_reg <= obyte_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        byte_next  = byte_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        obyte_next = obyte_reg;
        olen_next  = olen_reg;
        olast_next = olast_reg;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    byte_next  = s_tdata;
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                state_next = ST_IDLE;
                if (cmd_reg == CMD_OVF)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                else if (is_term)
                begin
                    state_next = ST_CR;
                end
                else if (ovf_reg)
                begin
                    if (printable)
                    begin
                        state_next = ST_ECHO;
                    end
                end
                else if (count_reg < DEPTH_C)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (printable)
                    begin
                        state_next = ST_ECHO;
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_ECHO;
                    obyte_next = byte_reg;
                    olen_next  = '0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_ECHO;
                    obyte_next = CH_CR;
                    olen_next  = '0;
                    olast_next = 1'b0;
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_ECHO;
                    obyte_next = CH_LF;
                    olen_next  = '0;
                    olast_next = !has_cmd;
                    if (has_cmd)
                    begin
                        state_next = ST_CMD;
                    end
                    else
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_CMD;
                    obyte_next = rd_data;
                    olen_next  = LEN_W'(count_reg);
                    olast_next = cmd_last;
                    if (cmd_last)
                    begin
                        idx_next   = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W - LEN_W - 8){1'b0}}, olen_reg, obyte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = olast_reg;

    // fill count never runs past the store
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("fill count beyond line store");

    // never overwrite a beat that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n) out_load |-> out_free)
        else $error("output register overwritten");

    // command readout only for a valid, non-overflowed line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMD) |-> (count_reg != '0 && !ovf_reg && idx_reg < count_reg))
        else $error("command readout on empty or overflowed line");

    // a store write only while there is room
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> (count_reg < DEPTH_C))
        else $error("write to full line store");

    // line is cleared after its last command beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMD && out_free && cmd_last) |=>
        (count_reg == '0 && !ovf_reg && m_tvalid_reg && m_tlast))
        else $error("line not cleared after command");

endmodule
`default_nettype wire

// ----- tb/tb_serial_command_line_assembler.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the serial command line assembler. Received
// beats are queued up front and driven with random gaps. Every accepted
// beat is run through a local line model, which queues the echo and
// command beats it should cause. A monitor compares each output beat
// with the oldest queued one.
module tb_serial_command_line_assembler;
    import scla_pkg::*;

    localparam int LINE_CAP    = 16;
    localparam int STORE_DEPTH = LINE_CAP - 1;
    localparam int RAND_ITEMS  = 125;
    localparam int LONG_HOLD   = 300;       // receiver hold-off, in cycles
    localparam int HOLD_AFTER  = 30;        // beats accepted before the hold-off
    localparam int DRAIN_CYC   = 40;        // quiet wait after the last expected beat
    localparam int CYCLE_LIMIT = 1000000;

    // one received beat: s_tuser = cmd, s_tdata = rx_byte
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx;
    } rx_beat_t;

    // one transmitted beat as the line model predicts it
    typedef struct packed {
        logic             kind;
        logic [7:0]       ch;
        logic [LEN_W-1:0] len;
        logic             run_end;
    } tx_beat_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    serial_command_line_assembler #(
        .LINE_CAPACITY (LINE_CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] rx_byte
        .s_tuser  (s_tuser),    // [0] cmd
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte, [11:8] command_length
        .m_tuser  (m_tuser),    // [0] kind
        .m_tlast  (m_tlast)     // last_of_run
    );

    initial begin
        forever #10 clk = ~clk;
    end

    rx_beat_t rx_beat_q[$];     // beats still to be offered
    tx_beat_t tx_beat_q[$];     // predicted output beats, oldest first

    // line model state
    logic [7:0] line_buf [STORE_DEPTH];
    int         line_len = 0;
    logic       line_ovf = 1'b0;

    int   n_accepted = 0;
    int   n_fail     = 0;
    logic calm       = 1'b0;    // stretch with no idling on either side

    // ------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------
    function automatic bit is_printable(logic [7:0] c);
        return c >= PRINT_LO && c <= PRINT_HI;
    endfunction

    function automatic void queue_tx(logic kind, logic [7:0] c, int len);
        tx_beat_t b;
        b.kind    = kind;
        b.ch      = c;
        b.len     = LEN_W'(len);    // length wraps to 4 bits on big stores
        b.run_end = 1'b0;
        tx_beat_q.push_back(b);
    endfunction

    // Advances the line state by one accepted beat and queues its results.
    function automatic void assemble_line(rx_beat_t rb);
        int       n_before;
        tx_beat_t tail;
        if (rb.cmd == CMD_OVF) begin
            // receive overflow wipes the line, nothing goes out
            line_len = 0;
            line_ovf = 1'b0;
            return;
        end
        n_before = tx_beat_q.size();
        if (rb.rx == CH_CR || rb.rx == CH_LF) begin
            queue_tx(KIND_ECHO, CH_CR, 0);
            queue_tx(KIND_ECHO, CH_LF, 0);
            if (line_len > 0 && !line_ovf) begin
                for (int i = 0; i < line_len && i < STORE_DEPTH; i++)
                    queue_tx(KIND_CMD, line_buf[i], line_len);
            end
            line_len = 0;
            line_ovf = 1'b0;
        end else if (line_ovf) begin
            if (is_printable(rb.rx))
                queue_tx(KIND_ECHO, rb.rx, 0);
        end else if (line_len < STORE_DEPTH) begin
            line_buf[line_len] = rb.rx;
            line_len++;
            if (is_printable(rb.rx))
                queue_tx(KIND_ECHO, rb.rx, 0);
        end else begin
            // store full: byte dropped silently, line marked overflowed
            line_ovf = 1'b1;
        end
        if (tx_beat_q.size() > n_before) begin
            tail = tx_beat_q[tx_beat_q.size() - 1];
            tail.run_end = 1'b1;
            tx_beat_q[tx_beat_q.size() - 1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(logic [7:0] c);
        rx_beat_q.push_back('{cmd: CMD_BYTE, rx: c});
    endtask

    // rx_byte is don't-care here, keep it random so its bits still toggle
    task automatic push_ovf();
        rx_beat_q.push_back('{cmd: CMD_OVF, rx: 8'($urandom)});
    endtask

    // printable most of the time, never a terminator
    function automatic logic [7:0] line_char();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(PRINT_LO, PRINT_HI));
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // lengths past the store depth push the line into overflow
    function automatic int line_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 8);
        else if (r < 85)
            return $urandom_range(9, STORE_DEPTH - 1);
        return $urandom_range(STORE_DEPTH, STORE_DEPTH + 3);
    endfunction

    // ------------------------------------------------------------------
    // Sender: pops the next beat once the current one is taken
    // ------------------------------------------------------------------
    int       rx_gap = 0;
    rx_beat_t rx_next;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            rx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                assemble_line('{cmd: s_tuser, rx: s_tdata});
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (rx_gap > 0) begin
                    rx_gap   <= rx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (rx_beat_q.size() > 0) begin
                    rx_next  = rx_beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= rx_next.cmd;
                    s_tdata  <= rx_next.rx;
                    rx_gap   <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off so the block backs
    // up into its input while beats keep being offered
    // ------------------------------------------------------------------
    int   tx_stall  = 0;
    int   hold_left = 0;
    logic held_once = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            tx_stall  <= 0;
            hold_left <= 0;
            held_once <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!held_once && n_accepted >= HOLD_AFTER) begin
            m_tready  <= 1'b0;
            held_once <= 1'b1;
            hold_left <= LONG_HOLD - 1;
        end else if (tx_stall > 0) begin
            m_tready <= 1'b0;
            tx_stall <= tx_stall - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            tx_stall <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // flip between idling and no-idling stretches
    initial begin
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm <= ~calm;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each accepted output beat against the oldest prediction
    // ------------------------------------------------------------------
    tx_beat_t tx_want;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (tx_beat_q.size() == 0) begin
                $error("unexpected beat: kind %0d out_byte %0h", m_tuser, m_tdata[7:0]);
                n_fail++;
            end else begin
                tx_want = tx_beat_q.pop_front();
                if (m_tuser !== tx_want.kind) begin
                    $error("kind: expected %0d, got %0d", tx_want.kind, m_tuser);
                    n_fail++;
                end
                if (m_tdata[7:0] !== tx_want.ch) begin
                    $error("out_byte: expected %0h, got %0h", tx_want.ch, m_tdata[7:0]);
                    n_fail++;
                end
                if (m_tdata[11:8] !== tx_want.len) begin
                    $error("command_length: expected %0d, got %0d",
                           tx_want.len, m_tdata[11:8]);
                    n_fail++;
                end
                if (m_tdata[TDATA_W-1:12] !== '0) begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[TDATA_W-1:12]);
                    n_fail++;
                end
                if (m_tlast !== tx_want.run_end) begin
                    $error("last_of_run: expected %0d, got %0d", tx_want.run_end, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cycle_cnt = 0;

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int         n_directed;
        int         r;
        int         len;
        int         ovf_at;
        logic [7:0] fill [STORE_DEPTH];

        // directed: overflow and terminator on an empty line
        push_ovf();
        push_byte(CH_LF);
        // a full store of extremes, then CR: two echoes plus 15 command beats
        fill = '{8'h41, 8'h00, 8'hFF, 8'h20, 8'h7E, 8'h7F, 8'h1F, 8'h80,
                 8'h09, 8'h61, 8'h55, 8'hAA, 8'h30, 8'h7A, 8'h01};
        for (int i = 0; i < STORE_DEPTH; i++)
            push_byte(fill[i]);
        push_byte(CH_CR);
        // overflow event drops a partial line; the CR after it is echo only
        push_byte(8'h78);
        push_ovf();
        push_byte(CH_CR);
        // a short line ended by LF
        push_byte(8'h71);
        push_byte(CH_LF);
        n_directed = rx_beat_q.size();

        // random: mostly whole lines; a line drawn first is longer than the store
        len = STORE_DEPTH + 2;
        while (rx_beat_q.size() - n_directed < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                ovf_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
                for (int i = 0; i < len; i++) begin
                    if (i == ovf_at)
                        push_ovf();
                    push_byte(line_char());
                end
                push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
            end else if (r < 92) begin
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_ovf();
            end
            len = line_size();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (rx_beat_q.size() > 0 || s_tvalid)
            @(posedge clk);
        while (tx_beat_q.size() > 0)
            @(posedge clk);
        // anything arriving now is flagged by the monitor
        repeat (DRAIN_CYC) @(posedge clk);

        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
